/* design/dfsm_pkg.sv */
// shared constants, codes and the twiddle cosine generator for the spectrum filter
package dfsm_pkg;

   // fixed field widths of the ports
   localparam int IDX_WIDTH      = 11;
   localparam int COEFF_IN_WIDTH = 16;
   localparam int CFG_WIDTH      = 4;

   // reset value of log2 of the coefficient count
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = 4'd10;

   // transaction kinds on req_type
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_FILTER = 1'b1;

   // pi in Q30
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // taylor series divisors (2n-1)*2n for n = 1..10
   localparam int TAYLOR_TERMS = 10;
   localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
      64'd132, 64'd182, 64'd240, 64'd306, 64'd380
   };

   // cosine of a Q30 angle in Q30, ten-term taylor series, floored at zero
   function automatic logic [63:0] cos_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = 64'sd1 <<< 30;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

endpackage

/* design/dct2_filter_spectrum_multiply_top.sv */
// spectrum bin times dct-ii filter response, six-stage pipeline
//
// One transaction is taken every clock: busy never rises, so start alone
// issues a coefficient load or a bin filter. A filter transaction shows its
// result on the rsp_ ports for one cycle; a load gives no result and writes
// the coefficient store at the accepting edge, so a filter in the very next
// cycle already sees it. The latency is set by the store/rom read in front,
// the coefficient times twiddle multiply and its rounding, the bin times
// response multiply, the adder that combines its partial products and the
// final rounding and saturation. The coefficient store has no clearing pass:
// every entry a filter uses must have been loaded first. The receiver cannot
// stall; csr_wr_en may be used only while no filter transaction is in flight.
module dct2_filter_spectrum_multiply_top #(
   parameter int COEFF_DEPTH   = 1024,
   parameter int SAMPLE_WIDTH  = 24,
   parameter int COEFF_WIDTH   = 16,
   parameter int TWIDDLE_WIDTH = 18
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic [dfsm_pkg::IDX_WIDTH-1:0]        req_bin_index,
   input  logic signed [dfsm_pkg::COEFF_IN_WIDTH-1:0] req_coeff_value,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_bin_real,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_bin_imag,
   // response channel
   output logic                                  rsp_valid,
   output logic [dfsm_pkg::IDX_WIDTH-1:0]        rsp_out_index,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_real,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_imag,
   output logic                                  rsp_saturated,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [dfsm_pkg::CFG_WIDTH-1:0]        csr_wr_data
);

   localparam int IDX_W      = dfsm_pkg::IDX_WIDTH;
   localparam int DEPTH_LOG2 = $clog2(COEFF_DEPTH + 1) - 1;
   localparam int ADDR_WIDTH = $clog2(COEFF_DEPTH);
   localparam int K_WIDTH    = DEPTH_LOG2 + 1;
   localparam int KX_WIDTH   = K_WIDTH + 1;
   localparam int FRAC       = TWIDDLE_WIDTH - 1;
   localparam int CFRAC      = COEFF_WIDTH - 2;
   localparam int TAP_W      = TWIDDLE_WIDTH + 1;
   localparam int P1_W       = COEFF_WIDTH + TAP_W;
   localparam int H_W        = TWIDDLE_WIDTH + 3;
   localparam int P2_W       = SAMPLE_WIDTH + H_W;
   localparam int Y_W        = P2_W + 1;
   localparam int R_W        = Y_W + 1;

   localparam logic [4:0]                LD5      = 5'(DEPTH_LOG2);
   localparam logic [K_WIDTH-1:0]        Q_K      = K_WIDTH'(64'd1 << DEPTH_LOG2);
   localparam logic signed [TAP_W-1:0]   ONE_TAP  = TAP_W'(64'd1 << FRAC);
   localparam logic signed [P1_W-1:0]    HALF_C   = P1_W'(64'd1 << (CFRAC - 1));
   localparam logic signed [R_W-1:0]     HALF_F   = R_W'(64'd1 << (FRAC - 1));
   localparam logic signed [R_W-1:0]     SAT_HI   = R_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [R_W-1:0]     SAT_LO   = R_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
   localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = SAMPLE_WIDTH'(SAT_HI);
   localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = SAMPLE_WIDTH'(SAT_LO);

   logic accept;

   // never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration register
   logic [dfsm_pkg::CFG_WIDTH-1:0] log2_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_count_ff <= dfsm_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         log2_count_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // stage 0: bin decode, store and rom addresses
   // ---------------------------------------------------------------
   logic [4:0]            l_raw;
   logic [4:0]            l_eff;
   logic [KX_WIDTH-1:0]   n_wide;
   logic [K_WIDTH-1:0]    n_k;
   logic [K_WIDTH-1:0]    k_mask;
   logic [K_WIDTH-1:0]    k_val;
   logic [K_WIDTH-1:0]    m_val;
   logic [K_WIDTH-1:0]    cos_addr;
   logic [K_WIDTH-1:0]    sin_addr;
   logic                  cos_neg;
   logic [K_WIDTH-1:0]    h_sel;
   logic                  k_zero;
   logic                  k_nyq;
   logic                  k_high;
   logic                  load_wr;

   // clamp log2 count into 1..DEPTH_LOG2
   always_comb begin
      l_raw = {1'b0, log2_count_ff};
      if (log2_count_ff == '0) begin
         l_eff = 5'd1;
      end else if (l_raw > LD5) begin
         l_eff = LD5;
      end else begin
         l_eff = l_raw;
      end
   end

   // bin index wrapped to 2N, angle index and quadrant fold
   always_comb begin
      n_wide = KX_WIDTH'(1) << l_eff;
      n_k    = K_WIDTH'(n_wide);
      k_mask = K_WIDTH'((n_wide << 1) - KX_WIDTH'(1));
      k_val  = K_WIDTH'(req_bin_index) & k_mask;
      m_val  = k_val << (LD5 - l_eff);
      if (m_val <= Q_K) begin
         cos_addr = m_val;
         sin_addr = Q_K - m_val;
         cos_neg  = 1'b0;
      end else begin
         cos_addr = -m_val;
         sin_addr = m_val - Q_K;
         cos_neg  = 1'b1;
      end
      k_zero = (k_val == '0);
      k_nyq  = (k_val == n_k);
      k_high = (k_val > n_k);
      h_sel  = k_high ? ((n_k << 1) - k_val) : k_val;
   end

   assign load_wr = accept && (req_type == dfsm_pkg::REQ_LOAD)
                    && (32'(req_bin_index) < 32'(COEFF_DEPTH));

   // coefficient store, write on load, registered read every cycle
   logic signed [COEFF_WIDTH-1:0] coeff_store_ff [0:COEFF_DEPTH-1];
   logic signed [COEFF_WIDTH-1:0] h_rd_ff;

   always_ff @(posedge clock) begin
      if (load_wr) begin
         coeff_store_ff[ADDR_WIDTH'(req_bin_index)] <= COEFF_WIDTH'(req_coeff_value);
      end
      h_rd_ff <= coeff_store_ff[ADDR_WIDTH'(h_sel)];
   end

   logic [FRAC-1:0] cos_rd;
   logic [FRAC-1:0] sin_rd;

   dfsm_twiddle_rom #(
      .DEPTH_LOG2    (DEPTH_LOG2),
      .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
   ) u_twiddle (
      .clock    (clock),
      .cos_addr (cos_addr),
      .sin_addr (sin_addr),
      .cos_data (cos_rd),
      .sin_data (sin_rd)
   );

   // ---------------------------------------------------------------
   // pipeline valid bits
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;
   logic s5_valid_ff;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept && (req_type == dfsm_pkg::REQ_FILTER);
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: coefficient times twiddle
   // ---------------------------------------------------------------
   logic [IDX_W-1:0]               s1_index_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_x_re_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_x_im_ff;
   logic                           s1_zero_ff;
   logic                           s1_nyq_ff;
   logic                           s1_high_ff;
   logic                           s1_cneg_ff;

   always_ff @(posedge clock) begin
      s1_index_ff <= req_bin_index;
      s1_x_re_ff  <= req_bin_real;
      s1_x_im_ff  <= req_bin_imag;
      s1_zero_ff  <= k_zero;
      s1_nyq_ff   <= k_nyq;
      s1_high_ff  <= k_high;
      s1_cneg_ff  <= cos_neg;
   end

   logic signed [TAP_W-1:0]       c_pos;
   logic signed [TAP_W-1:0]       c_tap;
   logic signed [TAP_W-1:0]       s_tap;
   logic signed [COEFF_WIDTH-1:0] h_op;

   // k = 0 takes h[0] as real, k = N takes zero
   always_comb begin
      c_pos = signed'(TAP_W'(cos_rd));
      if (s1_zero_ff) begin
         c_tap = ONE_TAP;
         s_tap = '0;
      end else begin
         c_tap = s1_cneg_ff ? -c_pos : c_pos;
         s_tap = signed'(TAP_W'(sin_rd));
      end
      h_op = s1_nyq_ff ? '0 : h_rd_ff;
   end

   logic signed [P1_W-1:0]         s2_pc_ff;
   logic signed [P1_W-1:0]         s2_ps_ff;
   logic [IDX_W-1:0]               s2_index_ff;
   logic signed [SAMPLE_WIDTH-1:0] s2_x_re_ff;
   logic signed [SAMPLE_WIDTH-1:0] s2_x_im_ff;
   logic                           s2_nyq_ff;
   logic                           s2_high_ff;

   always_ff @(posedge clock) begin
      s2_pc_ff    <= h_op * c_tap;
      s2_ps_ff    <= h_op * s_tap;
      s2_index_ff <= s1_index_ff;
      s2_x_re_ff  <= s1_x_re_ff;
      s2_x_im_ff  <= s1_x_im_ff;
      s2_nyq_ff   <= s1_nyq_ff;
      s2_high_ff  <= s1_high_ff;
   end

   // ---------------------------------------------------------------
   // stage 2: round response to twiddle precision, negate above N
   // ---------------------------------------------------------------
   logic signed [P1_W-1:0] pc_sum;
   logic signed [P1_W-1:0] ps_sum;
   logic signed [H_W-1:0]  h_re_rnd;
   logic signed [H_W-1:0]  h_im_rnd;
   logic signed [H_W-1:0]  h_re_in;
   logic signed [H_W-1:0]  h_im_in;

   always_comb begin
      pc_sum   = s2_pc_ff + HALF_C;
      ps_sum   = s2_ps_ff + HALF_C;
      h_re_rnd = H_W'(pc_sum >>> CFRAC);
      h_im_rnd = H_W'(ps_sum >>> CFRAC);
      h_re_in  = s2_high_ff ? -h_re_rnd : h_re_rnd;
      h_im_in  = s2_high_ff ? -h_im_rnd : h_im_rnd;
   end

   logic signed [H_W-1:0]          s3_h_re_ff;
   logic signed [H_W-1:0]          s3_h_im_ff;
   logic [IDX_W-1:0]               s3_index_ff;
   logic signed [SAMPLE_WIDTH-1:0] s3_x_re_ff;
   logic signed [SAMPLE_WIDTH-1:0] s3_x_im_ff;
   logic                           s3_nyq_ff;

   always_ff @(posedge clock) begin
      s3_h_re_ff  <= h_re_in;
      s3_h_im_ff  <= h_im_in;
      s3_index_ff <= s2_index_ff;
      s3_x_re_ff  <= s2_x_re_ff;
      s3_x_im_ff  <= s2_x_im_ff;
      s3_nyq_ff   <= s2_nyq_ff;
   end

   // ---------------------------------------------------------------
   // stage 3: four partial products of the complex multiply
   // ---------------------------------------------------------------
   logic signed [P2_W-1:0] s4_rr_ff;
   logic signed [P2_W-1:0] s4_ii_ff;
   logic signed [P2_W-1:0] s4_ri_ff;
   logic signed [P2_W-1:0] s4_ir_ff;
   logic [IDX_W-1:0]       s4_index_ff;

   always_ff @(posedge clock) begin
      s4_rr_ff    <= s3_x_re_ff * s3_h_re_ff;
      s4_ii_ff    <= s3_x_im_ff * s3_h_im_ff;
      s4_ri_ff    <= s3_x_re_ff * s3_h_im_ff;
      s4_ir_ff    <= s3_x_im_ff * s3_h_re_ff;
      s4_index_ff <= s3_index_ff;
   end

   // ---------------------------------------------------------------
   // stage 4: combine partial products
   // ---------------------------------------------------------------
   logic signed [Y_W-1:0] s5_y_re_ff;
   logic signed [Y_W-1:0] s5_y_im_ff;
   logic [IDX_W-1:0]      s5_index_ff;

   always_ff @(posedge clock) begin
      s5_y_re_ff  <= Y_W'(s4_rr_ff) - Y_W'(s4_ii_ff);
      s5_y_im_ff  <= Y_W'(s4_ri_ff) + Y_W'(s4_ir_ff);
      s5_index_ff <= s4_index_ff;
   end

   // ---------------------------------------------------------------
   // stage 5: round to integer and saturate
   // ---------------------------------------------------------------
   logic signed [R_W-1:0]          y_re_rnd;
   logic signed [R_W-1:0]          y_im_rnd;
   logic signed [SAMPLE_WIDTH-1:0] out_re_in;
   logic signed [SAMPLE_WIDTH-1:0] out_im_in;
   logic                           clip_re;
   logic                           clip_im;

   always_comb begin
      y_re_rnd = (R_W'(s5_y_re_ff) + HALF_F) >>> FRAC;
      y_im_rnd = (R_W'(s5_y_im_ff) + HALF_F) >>> FRAC;
      clip_re  = (y_re_rnd > SAT_HI) || (y_re_rnd < SAT_LO);
      clip_im  = (y_im_rnd > SAT_HI) || (y_im_rnd < SAT_LO);
      if (y_re_rnd > SAT_HI) begin
         out_re_in = OUT_MAX;
      end else if (y_re_rnd < SAT_LO) begin
         out_re_in = OUT_MIN;
      end else begin
         out_re_in = SAMPLE_WIDTH'(y_re_rnd);
      end
      if (y_im_rnd > SAT_HI) begin
         out_im_in = OUT_MAX;
      end else if (y_im_rnd < SAT_LO) begin
         out_im_in = OUT_MIN;
      end else begin
         out_im_in = SAMPLE_WIDTH'(y_im_rnd);
      end
   end

   logic [IDX_W-1:0]               rsp_index_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_real_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_imag_ff;
   logic                           rsp_sat_ff;

   always_ff @(posedge clock) begin
      rsp_index_ff <= s5_index_ff;
      rsp_real_ff  <= out_re_in;
      rsp_imag_ff  <= out_im_in;
      rsp_sat_ff   <= clip_re || clip_im;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_real  = rsp_real_ff;
   assign rsp_out_imag  = rsp_imag_ff;
   assign rsp_saturated = rsp_sat_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------

   // a result carries the index of its filter transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_index == $past(req_bin_index, 6)))
      else $error("result index does not match its request");

   // a load never produces a result
   assert property (@(posedge clock) disable iff (reset)
      $past(accept && (req_type == dfsm_pkg::REQ_LOAD), 6) |-> !rsp_valid)
      else $error("result produced for a coefficient load");

   // the bin at N has a zero response
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_nyq_ff) |-> ((s3_h_re_ff == '0) && (s3_h_im_ff == '0)))
      else $error("nonzero response at bin N");

   // a clipped result sits on a rail
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         ((rsp_out_real == OUT_MAX) || (rsp_out_real == OUT_MIN)
          || (rsp_out_imag == OUT_MAX) || (rsp_out_imag == OUT_MIN)))
      else $error("saturation flag without a clipped part");

endmodule

/* design/dfsm_twiddle_rom.sv */
// quarter-wave cosine rom with two registered read ports
module dfsm_twiddle_rom #(
   parameter int DEPTH_LOG2    = 10,
   parameter int TWIDDLE_WIDTH = 18
) (
   input  logic                     clock,
   input  logic [DEPTH_LOG2:0]      cos_addr,
   input  logic [DEPTH_LOG2:0]      sin_addr,
   output logic [TWIDDLE_WIDTH-2:0] cos_data,
   output logic [TWIDDLE_WIDTH-2:0] sin_data
);

   localparam int FRAC     = TWIDDLE_WIDTH - 1;
   localparam int QUARTER  = 1 << DEPTH_LOG2;
   localparam logic [63:0] MAX_WORD = (64'd1 << FRAC) - 64'd1;

   typedef logic [FRAC-1:0] word_type;
   typedef word_type rom_type [0:QUARTER];

   // cos(pi/2 * i/Q) scaled to FRAC fraction bits, rounded half up, clamped
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] angle;
      logic [63:0] cval;
      logic [63:0] scaled;
      for (int i = 0; i <= QUARTER; i++) begin
         angle  = (dfsm_pkg::PI_Q30 * 64'(i)) >> (DEPTH_LOG2 + 1);
         cval   = dfsm_pkg::cos_q30(angle);
         scaled = (cval + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
         rom[i] = (scaled > MAX_WORD) ? word_type'(MAX_WORD) : word_type'(scaled);
      end
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic [FRAC-1:0] cos_data_ff;
   logic [FRAC-1:0] sin_data_ff;

   // registered reads
   always_ff @(posedge clock) begin
      cos_data_ff <= COS_ROM[cos_addr];
      sin_data_ff <= COS_ROM[sin_addr];
   end

   assign cos_data = cos_data_ff;
   assign sin_data = sin_data_ff;

endmodule

/* verif/dfsm_checker.sv */
// checker for the spectrum filter: predicts every filtered bin and compares the results
module dfsm_checker (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic                                        busy,
   input  logic                                        req_type,
   input  logic [dfsm_pkg::IDX_WIDTH-1:0]              req_bin_index,
   input  logic signed [dfsm_pkg::COEFF_IN_WIDTH-1:0]  req_coeff_value,
   input  logic signed [23:0]                          req_bin_real,
   input  logic signed [23:0]                          req_bin_imag,
   input  logic                                        rsp_valid,
   input  logic [dfsm_pkg::IDX_WIDTH-1:0]              rsp_out_index,
   input  logic signed [23:0]                          rsp_out_real,
   input  logic signed [23:0]                          rsp_out_imag,
   input  logic                                        rsp_saturated,
   input  logic                                        csr_wr_en,
   input  logic [dfsm_pkg::CFG_WIDTH-1:0]              csr_wr_data,
   output int                                          fail_count,
   output int                                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W    = 24;
   localparam int STORE_DEPTH = 1024;
   localparam int DEPTH_LOG2  = 10;
   localparam int QUARTER     = 1 << DEPTH_LOG2;
   localparam int TW_FRAC     = 17;
   localparam int COEFF_FRAC  = 14;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam longint unsigned PI_FIXED = 64'd3373259426;

   typedef struct {
      logic [dfsm_pkg::IDX_WIDTH-1:0] index;
      logic signed [SAMPLE_W-1:0]     re;
      logic signed [SAMPLE_W-1:0]     im;
      logic                           sat;
   } bin_result_type;

   // block state as the predictor sees it
   logic signed [dfsm_pkg::COEFF_IN_WIDTH-1:0] coeff_mem [0:STORE_DEPTH-1];
   logic [dfsm_pkg::CFG_WIDTH-1:0]             cfg_log2 = dfsm_pkg::CFG_RESET;
   int                                         cos_rom [0:QUARTER];
   bin_result_type                             expected_bins [$];
   int                                         errors = 0;

   assign fail_count = errors;

   // cosine of a Q30 angle in Q30 from a ten-term series, floored at zero
   function automatic longint taylor_cos_q30(input longint unsigned angle);
      longint unsigned sq;
      longint unsigned term;
      longint          acc;
      sq   = (angle * angle) >> 30;
      term = 64'd1 << 30;
      acc  = 64'sd1 <<< 30;
      for (int n = 1; n <= 10; n++) begin
         term = ((term * sq) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      return (acc < 0) ? 64'sd0 : acc;
   endfunction

   // add half an lsb, then floor
   function automatic longint round_half_up(input longint v, input int shift);
      return (v + (64'sd1 <<< (shift - 1))) >>> shift;
   endfunction

   function automatic longint clip_sample(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // quarter-wave twiddle table
   initial begin
      longint unsigned angle;
      longint          level;
      for (int i = 0; i <= QUARTER; i++) begin
         angle = (PI_FIXED * 64'(i)) / 64'(2 * QUARTER);
         level = (taylor_cos_q30(angle) + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
         if (level > (64'sd1 <<< TW_FRAC) - 1) begin
            level = (64'sd1 <<< TW_FRAC) - 1;
         end
         cos_rom[i] = int'(level);
      end
   end

   // bin times the filter response built from the coefficient store
   function automatic bin_result_type predict_bin(
         input logic [dfsm_pkg::IDX_WIDTH-1:0] idx,
         input logic signed [SAMPLE_W-1:0] x_re,
         input logic signed [SAMPLE_W-1:0] x_im);
      int             eff_log2;
      int             half_len;
      int             k;
      int             m;
      longint         tw_cos;
      longint         tw_sin;
      longint         h;
      longint         h_re;
      longint         h_im;
      longint         y_re;
      longint         y_im;
      longint         c_re;
      longint         c_im;
      bin_result_type res;
      eff_log2 = int'(cfg_log2);
      if (eff_log2 < 1) eff_log2 = 1;
      if (eff_log2 > DEPTH_LOG2) eff_log2 = DEPTH_LOG2;
      half_len = 1 << eff_log2;
      k = int'(idx) & (2 * half_len - 1);
      m = k << (DEPTH_LOG2 - eff_log2);
      // twiddle by quarter-wave symmetry
      if (m <= QUARTER) begin
         tw_cos = cos_rom[m];
         tw_sin = cos_rom[QUARTER - m];
      end else begin
         tw_cos = -longint'(cos_rom[2 * QUARTER - m]);
         tw_sin = cos_rom[m - QUARTER];
      end
      // response: dc term, lower half, nyquist zero, mirrored upper half
      h_re = 0;
      h_im = 0;
      if (k == 0) begin
         h_re = round_half_up(longint'(coeff_mem[0]) * (64'sd1 <<< TW_FRAC), COEFF_FRAC);
      end else if (k < half_len) begin
         h    = coeff_mem[k];
         h_re = round_half_up(h * tw_cos, COEFF_FRAC);
         h_im = round_half_up(h * tw_sin, COEFF_FRAC);
      end else if (k > half_len) begin
         h    = coeff_mem[2 * half_len - k];
         h_re = -round_half_up(h * tw_cos, COEFF_FRAC);
         h_im = -round_half_up(h * tw_sin, COEFF_FRAC);
      end
      // complex product, rounded and clipped
      y_re = round_half_up(longint'(x_re) * h_re - longint'(x_im) * h_im, TW_FRAC);
      y_im = round_half_up(longint'(x_re) * h_im + longint'(x_im) * h_re, TW_FRAC);
      c_re = clip_sample(y_re);
      c_im = clip_sample(y_im);
      res.index = idx;
      res.re    = c_re[SAMPLE_W-1:0];
      res.im    = c_im[SAMPLE_W-1:0];
      res.sat   = (c_re != y_re) || (c_im != y_im);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (errors < 40) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      bin_result_type want;
      if (reset) begin
         expected_bins.delete();
         cfg_log2 = dfsm_pkg::CFG_RESET;
      end else begin
         // result transaction against the oldest prediction
         if (rsp_valid) begin
            if (expected_bins.size() == 0) begin
               report_mismatch($sformatf("result for bin %0d with none expected", rsp_out_index));
            end else begin
               want = expected_bins.pop_front();
               if (rsp_out_index !== want.index)
                  report_mismatch($sformatf("index %0d, expected %0d",
                                            rsp_out_index, want.index));
               if (rsp_out_real !== want.re)
                  report_mismatch($sformatf("bin %0d real %0d, expected %0d",
                                            want.index, rsp_out_real, want.re));
               if (rsp_out_imag !== want.im)
                  report_mismatch($sformatf("bin %0d imag %0d, expected %0d",
                                            want.index, rsp_out_imag, want.im));
               if (rsp_saturated !== want.sat)
                  report_mismatch($sformatf("bin %0d saturated %b, expected %b",
                                            want.index, rsp_saturated, want.sat));
            end
         end
         if (csr_wr_en) begin
            cfg_log2 = csr_wr_data;
         end
         // request transaction
         if (start && !busy) begin
            if (req_type == dfsm_pkg::REQ_LOAD) begin
               if (req_bin_index < STORE_DEPTH) begin
                  coeff_mem[req_bin_index] = req_coeff_value;
               end
            end else begin
               expected_bins.push_back(predict_bin(req_bin_index, req_bin_real, req_bin_imag));
            end
         end
      end
      pending_count <= expected_bins.size();
   end

endmodule

/* verif/testbench.sv */
// stimulus, clock, reset and verdict for the spectrum filter block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 1024;
   localparam int DEPTH_LOG2  = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 10;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 166;

   logic                                        clock;
   logic                                        reset           = 1'b1;
   logic                                        start           = 1'b0;
   logic                                        busy;
   logic                                        req_type        = dfsm_pkg::REQ_LOAD;
   logic [dfsm_pkg::IDX_WIDTH-1:0]              req_bin_index   = '0;
   logic signed [dfsm_pkg::COEFF_IN_WIDTH-1:0]  req_coeff_value = '0;
   logic signed [23:0]                          req_bin_real    = '0;
   logic signed [23:0]                          req_bin_imag    = '0;
   logic                                        rsp_valid;
   logic [dfsm_pkg::IDX_WIDTH-1:0]              rsp_out_index;
   logic signed [23:0]                          rsp_out_real;
   logic signed [23:0]                          rsp_out_imag;
   logic                                        rsp_saturated;
   logic                                        csr_wr_en       = 1'b0;
   logic [dfsm_pkg::CFG_WIDTH-1:0]              csr_wr_data     = '0;
   int                                          fail_count;
   int                                          pending_count;
   int                                          cycle_count     = 0;
   int                                          sent_count      = 0;

   // which coefficients hold a value, and the setting last written
   bit                                          coeff_written [0:STORE_DEPTH-1];
   int                                          cur_log2        = int'(dfsm_pkg::CFG_RESET);

   dct2_filter_spectrum_multiply_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_bin_index   (req_bin_index),
      .req_coeff_value (req_coeff_value),
      .req_bin_real    (req_bin_real),
      .req_bin_imag    (req_bin_imag),
      .rsp_valid       (rsp_valid),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_real    (rsp_out_real),
      .rsp_out_imag    (rsp_out_imag),
      .rsp_saturated   (rsp_saturated),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   dfsm_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_bin_index   (req_bin_index),
      .req_coeff_value (req_coeff_value),
      .req_bin_real    (req_bin_real),
      .req_bin_imag    (req_bin_imag),
      .rsp_valid       (rsp_valid),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_real    (rsp_out_real),
      .rsp_out_imag    (rsp_out_imag),
      .rsp_saturated   (rsp_saturated),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // coefficient count N in effect for the current setting
   function automatic int half_length();
      int eff;
      eff = cur_log2;
      if (eff < 1) eff = 1;
      if (eff > DEPTH_LOG2) eff = DEPTH_LOG2;
      return 1 << eff;
   endfunction

   // coefficient a filter on this bin reads, or -1 at the nyquist bin
   function automatic int needed_entry(input logic [dfsm_pkg::IDX_WIDTH-1:0] idx);
      int n;
      int k;
      n = half_length();
      k = int'(idx) & (2 * n - 1);
      if (k == 0) return 0;
      if (k < n) return k;
      if (k == n) return -1;
      return 2 * n - k;
   endfunction

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(7))
         0:       return 24'sh7fffff;
         1:       return 24'sh800000;
         2:       return 24'(int'($urandom_range(200)) - 100);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic signed [dfsm_pkg::COEFF_IN_WIDTH-1:0] rand_coeff();
      case ($urandom_range(7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'(int'($urandom_range(40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   // one transaction, then an optional sender gap
   task automatic send_item(input logic kind, input logic [dfsm_pkg::IDX_WIDTH-1:0] idx,
                            input logic signed [dfsm_pkg::COEFF_IN_WIDTH-1:0] cv,
                            input logic signed [23:0] x_re, input logic signed [23:0] x_im,
                            input int idle_pct);
      start           <= 1'b1;
      req_type        <= kind;
      req_bin_index   <= idx;
      req_coeff_value <= cv;
      req_bin_real    <= x_re;
      req_bin_imag    <= x_im;
      do @(posedge clock); while (busy !== 1'b0);
      sent_count++;
      if (kind == dfsm_pkg::REQ_LOAD && idx < STORE_DEPTH) begin
         coeff_written[idx] = 1'b1;
      end
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // filter a bin, loading the coefficient it reads first if it has none yet
   task automatic filter_bin(input logic [dfsm_pkg::IDX_WIDTH-1:0] idx,
                             input logic signed [23:0] x_re, input logic signed [23:0] x_im,
                             input int idle_pct);
      int need;
      need = needed_entry(idx);
      if (need >= 0 && !coeff_written[need]) begin
         send_item(dfsm_pkg::REQ_LOAD, dfsm_pkg::IDX_WIDTH'(need), rand_coeff(),
                   rand_sample(), rand_sample(), idle_pct);
      end
      send_item(dfsm_pkg::REQ_FILTER, idx, rand_coeff(), x_re, x_im, idle_pct);
   endtask

   // register write once the pipeline has drained
   task automatic write_cfg(input int value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dfsm_pkg::CFG_WIDTH'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_log2 = value;
   endtask

   initial begin
      int cfg_plan [PHASES] = '{10, 1, 3, 15, 6, 0, 9, 2};
      int idle_plan [4]     = '{0, 47, 0, 29};
      int idle_pct;
      int phase_start;
      int n;
      logic [dfsm_pkg::IDX_WIDTH-1:0] idx;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme coefficients, ignored loads, dc, nyquist and mirrored bins
      send_item(dfsm_pkg::REQ_LOAD, 11'd0, 16'sh7fff, 24'sh0, 24'sh0, 0);
      send_item(dfsm_pkg::REQ_LOAD, 11'd1, 16'sh8000, 24'sh7fffff, 24'sh800000, 0);
      send_item(dfsm_pkg::REQ_LOAD, 11'd1023, 16'sd1, 24'sh0, 24'sh0, 0);
      send_item(dfsm_pkg::REQ_LOAD, 11'd512, -16'sd1, 24'sh0, 24'sh0, 0);
      send_item(dfsm_pkg::REQ_LOAD, 11'd1024, 16'sd12345, 24'sh0, 24'sh0, 0);
      send_item(dfsm_pkg::REQ_LOAD, 11'd2047, 16'sh8000, 24'sh0, 24'sh0, 0);
      filter_bin(11'd0, 24'sh7fffff, 24'sh7fffff, 0);
      filter_bin(11'd0, 24'sh800000, 24'sh800000, 0);
      filter_bin(11'd1, 24'sh800000, 24'sh800000, 0);
      filter_bin(11'd1023, 24'sh7fffff, 24'sh800000, 0);
      filter_bin(11'd1024, 24'sh7fffff, 24'sh7fffff, 0);
      filter_bin(11'd1025, 24'sd123456, -24'sd654321, 0);
      filter_bin(11'd2047, 24'sh7fffff, 24'sh7fffff, 0);
      filter_bin(11'd512, 24'sh0, 24'sh0, 0);
      filter_bin(11'd1536, -24'sd1, 24'sd1, 0);
      // load followed at once by a filter that reads it
      send_item(dfsm_pkg::REQ_LOAD, 11'd0, 16'sh0, 24'sh0, 24'sh0, 0);
      filter_bin(11'd0, 24'sd5, 24'sd5, 0);
      // below the register range, with wrapping bin indexes
      write_cfg(0);
      filter_bin(11'd2047, 24'sh7fffff, 24'sh7fffff, 0);
      filter_bin(11'd2, 24'sd1000, 24'sd1000, 0);
      filter_bin(11'd4, -24'sd77, 24'sd99, 0);

      // random phases, each under its own setting and idle rate
      for (int phase = 0; phase < PHASES; phase++) begin
         write_cfg(cfg_plan[phase]);
         idle_pct = idle_plan[phase % 4];
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            n = half_length();
            if ($urandom_range(3) == 0) begin
               // coefficient load, mostly inside the bins in use
               case ($urandom_range(15))
                  0:       idx = dfsm_pkg::IDX_WIDTH'($urandom_range(STORE_DEPTH, 2047));
                  1,2,3,4,5,6,7,8:
                           idx = dfsm_pkg::IDX_WIDTH'($urandom_range(0,
                                    (n < STORE_DEPTH) ? n : n - 1));
                  default: idx = dfsm_pkg::IDX_WIDTH'($urandom_range(0, STORE_DEPTH - 1));
               endcase
               send_item(dfsm_pkg::REQ_LOAD, idx, rand_coeff(), rand_sample(), rand_sample(),
                         idle_pct);
            end else begin
               case ($urandom_range(9))
                  0:       idx = dfsm_pkg::IDX_WIDTH'(0);
                  1:       idx = dfsm_pkg::IDX_WIDTH'(n);
                  2:       idx = dfsm_pkg::IDX_WIDTH'($urandom_range(0, 2 * n - 1));
                  default: idx = dfsm_pkg::IDX_WIDTH'($urandom);
               endcase
               filter_bin(idx, rand_sample(), rand_sample(), idle_pct);
            end
         end
      end

      // drain and verdict
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
